// ----- hdl/crtc_pkg.sv -----
package crtc_pkg;

   // channel widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;

   // request kinds
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_PEN   = 2'd3
   } cmd_type;

   // bus port select
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // cursor blink modes, bits 6..5 of cursor start
   typedef enum logic [1:0] {
      CURSOR_STEADY = 2'd0,
      CURSOR_OFF    = 2'd1,
      CURSOR_FAST   = 2'd2,
      CURSOR_SLOW   = 2'd3
   } cursor_mode_type;

   // register file map
   localparam logic [4:0] REG_HT = 5'd0;
   localparam logic [4:0] REG_HD = 5'd1;
   localparam logic [4:0] REG_HS = 5'd2;
   localparam logic [4:0] REG_SW = 5'd3;
   localparam logic [4:0] REG_VT = 5'd4;
   localparam logic [4:0] REG_VA = 5'd5;
   localparam logic [4:0] REG_VD = 5'd6;
   localparam logic [4:0] REG_VS = 5'd7;
   localparam logic [4:0] REG_ML = 5'd9;
   localparam logic [4:0] REG_CS = 5'd10;
   localparam logic [4:0] REG_CE = 5'd11;
   localparam logic [4:0] REG_AH = 5'd12;
   localparam logic [4:0] REG_AL = 5'd13;
   localparam logic [4:0] REG_LH = 5'd16;
   localparam logic [4:0] REG_LL = 5'd17;

   localparam logic [4:0] VSYNC_LINES = 5'd16;

   // first member sits in the top bits: read_data ends up at bit 0
   typedef struct packed {
      logic [4:0]  row_address;
      logic [13:0] memory_address;
      logic        cursor_on;
      logic        display_enable;
      logic        vsync_active;
      logic        hsync_active;
      logic        vsync_start;
      logic        hsync_start;
      logic [7:0]  read_data;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(rsp_type);

endpackage

// ----- hdl/crtc_rsp_skid.sv -----
module crtc_rsp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  crtc_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output crtc_pkg::rsp_type out_data
);
   import crtc_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    take;
   logic    drain;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = in_valid && in_ready;
   assign drain     = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= take;
         end
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!drain && take) begin
         skid_data_ff <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !out_ready))
      else $error("skid filled while output was free");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && out_data_ff == $past(skid_data_ff))
      else $error("skid entry lost on drain");
`endif

endmodule

// ----- hdl/crt_controller_timing.sv -----
// Character-based CRT controller timing core. Each request is a character tick, a bus
// read or write of the index/data register pair, or a light-pen strobe, and each gives
// exactly one response describing the state after it. Requests are taken one per clock
// while req_tready is high; each response is registered in a two-entry output buffer
// that keeps req_tready high while one waits and drops it only when two are pending.
// The cycle time is set by the tick path: column step, horizontal and vertical total
// compares, row-start add, then the display-enable, cursor and address logic feeding
// the output register. Registers 12 and 13 (start address) and 14 to 17 read back; the
// rest are write-only and read as zero.
module crt_controller_timing #(
   parameter int REGISTER_COUNT = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [crtc_pkg::REQ_TDATA_W-1:0] req_tdata,  // write_data[7:0], blink_enable[8]
   input  logic [crtc_pkg::REQ_TUSER_W-1:0] req_tuser,  // command[1:0], bus_port[2]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_data[7:0], hsync_start[8], vsync_start[9], hsync_active[10],
   // vsync_active[11], display_enable[12], cursor_on[13], memory_address[27:14],
   // row_address[32:28]
   output logic [crtc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import crtc_pkg::*;

   localparam int         IDX_W     = $clog2(REGISTER_COUNT);
   localparam logic [5:0] REG_LIMIT = 6'(REGISTER_COUNT);

   logic [7:0]  regs_ff [REGISTER_COUNT];
   logic [7:0]  regs_in [REGISTER_COUNT];
   logic [4:0]  index_ff, index_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [8:0]  sl_ff, sl_in;
   logic [13:0] rsa_ff, rsa_in;    // only the low 14 bits of the row start are ever seen
   logic [7:0]  frame_ff, frame_in;
   logic [3:0]  hrem_ff, hrem_in;
   logic [4:0]  vrem_ff, vrem_in;

   cmd_type cmd;
   logic    port;
   logic [7:0] wdata;
   logic    blink;
   logic    accept;
   logic    hs_start, vs_start;
   rsp_type res_in;
   rsp_type rsp_res;

   assign cmd    = cmd_type'(req_tuser[1:0]);
   assign port   = req_tuser[2];
   assign wdata  = req_tdata[7:0];
   assign blink  = req_tdata[8];
   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      logic [7:0]  ht_total;
      logic [7:0]  vt_total;
      logic [13:0] start_addr;
      logic [13:0] cur_addr;

      ht_total   = regs_ff[REG_HT] + 8'd1;
      vt_total   = regs_ff[REG_VT] + 8'd1;
      start_addr = {regs_ff[REG_AH][5:0], regs_ff[REG_AL]};
      cur_addr   = rsa_ff + 14'(col_ff);

      regs_in  = regs_ff;
      index_in = index_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      sl_in    = sl_ff;
      rsa_in   = rsa_ff;
      frame_in = frame_ff;
      hrem_in  = hrem_ff;
      vrem_in  = vrem_ff;
      hs_start = 1'b0;
      vs_start = 1'b0;

      case (cmd)
         CMD_TICK: begin
            col_in = col_ff + 8'd1;
            if (col_in == regs_ff[REG_HS]) begin
               hrem_in  = regs_ff[REG_SW][3:0];
               hs_start = 1'b1;
            end else if (hrem_ff != 4'd0) begin
               hrem_in = hrem_ff - 4'd1;
            end
            // end of scan line
            if (col_in >= ht_total) begin
               col_in = 8'd0;
               if (vrem_ff != 5'd0) begin
                  vrem_in = vrem_ff - 5'd1;
               end
               sl_in = sl_ff + 9'd1;
               if (sl_in > {1'b0, regs_ff[REG_ML]} && row_ff < vt_total) begin
                  rsa_in = rsa_ff + 14'(regs_ff[REG_HD]);
                  sl_in  = 9'd0;
                  row_in = row_ff + 8'd1;
               end
               if (row_in == regs_ff[REG_VS] && sl_in == 9'd0) begin
                  vrem_in  = VSYNC_LINES;
                  vs_start = 1'b1;
                  frame_in = frame_ff + 8'd1;
                  rsa_in   = start_addr;
               end
               // end of frame, including vertical adjust lines
               if ((row_in == vt_total && sl_in >= {1'b0, regs_ff[REG_VA]})
                   || row_in > vt_total) begin
                  row_in = 8'd0;
                  rsa_in = start_addr;
                  sl_in  = 9'd0;
               end
            end
         end
         CMD_READ: begin
         end
         CMD_WRITE: begin
            if (port == PORT_INDEX) begin
               index_in = wdata[4:0];
            end else if ({1'b0, index_ff} < REG_LIMIT) begin
               regs_in[index_ff[IDX_W-1:0]] = wdata;
            end
         end
         CMD_PEN: begin
            regs_in[REG_LH] = {2'b00, cur_addr[13:8]};
            regs_in[REG_LL] = cur_addr[7:0];
         end
         default: begin
         end
      endcase
   end

   // response from the updated state
   always_comb begin
      logic [7:0] cs;
      logic       hide;

      cs   = regs_in[REG_CS];
      hide = 1'b0;
      case (cursor_mode_type'(cs[6:5]))
         CURSOR_STEADY: hide = 1'b0;
         CURSOR_OFF:    hide = 1'b1;
         CURSOR_FAST:   hide = blink && frame_in[4];
         CURSOR_SLOW:   hide = blink && frame_in[5];
         default:       hide = 1'b0;
      endcase

      res_in.read_data = 8'd0;
      if (cmd == CMD_READ) begin
         if (port == PORT_INDEX) begin
            res_in.read_data = {3'b000, index_ff};
         end else if (index_ff inside {[REG_AH:REG_LL]}) begin
            res_in.read_data = regs_ff[index_ff[IDX_W-1:0]];
         end
      end
      res_in.hsync_start    = hs_start;
      res_in.vsync_start    = vs_start;
      res_in.hsync_active   = hrem_in != 4'd0;
      res_in.vsync_active   = vrem_in != 5'd0;
      res_in.display_enable = (row_in < {1'b0, regs_in[REG_VD][6:0]})
                              && (col_in < regs_in[REG_HD]);
      res_in.cursor_on      = !hide
                              && sl_in >= {4'd0, cs[4:0]}
                              && sl_in <= {4'd0, regs_in[REG_CE][4:0]};
      res_in.memory_address = rsa_in + 14'(col_in);
      res_in.row_address    = sl_in[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            regs_ff[i] <= 8'd0;
         end
         index_ff <= 5'd0;
         col_ff   <= 8'd0;
         row_ff   <= 8'd0;
         sl_ff    <= 9'd0;
         rsa_ff   <= 14'd0;
         frame_ff <= 8'd0;
         hrem_ff  <= 4'd0;
         vrem_ff  <= 5'd0;
      end else if (accept) begin
         regs_ff  <= regs_in;
         index_ff <= index_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         sl_ff    <= sl_in;
         rsa_ff   <= rsa_in;
         frame_ff <= frame_in;
         hrem_ff  <= hrem_in;
         vrem_ff  <= vrem_in;
      end
   end

   crtc_rsp_skid u_rsp_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (res_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_res};

`ifndef SYNTHESIS
   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      accept && cmd != CMD_TICK |=> $stable(col_ff) && $stable(row_ff) && $stable(sl_ff))
      else $error("raster counters moved on a non-tick request");

   a_frame_on_vsync: assert property (@(posedge clock) disable iff (reset)
      accept && res_in.vsync_start |=> frame_ff == $past(frame_ff) + 8'd1)
      else $error("frame count not advanced at vsync start");

   a_index_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && cmd == CMD_WRITE && port == PORT_INDEX) |=> $stable(index_ff))
      else $error("index register changed without an index write");
`endif

endmodule
